// ===== design/ortlo_pkg.sv =====
package ortlo_pkg;

  // Grid geometry and number format
  localparam int GRID_SIDE = 512;
  localparam int FRAC_BITS = 8;
  localparam int COORD_W   = $clog2(GRID_SIDE);
  localparam int ADDR_W    = 2 * COORD_W;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int VAL_W     = 12;
  localparam int DIM_W     = 10;
  localparam int CNT_W     = 10;
  localparam int ERR_W     = COORD_W + 3;

  // Saturation bound, +/-4.0 in the cell format
  localparam int LIMIT_POS = 4 * (1 << FRAC_BITS);
  localparam logic signed [VAL_W:0] LIMIT_WIDE = (VAL_W + 1)'(LIMIT_POS);

  // Configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_HIT_STEP    = 2'd0,
    REG_MISS_STEP   = 2'd1,
    REG_GRID_WIDTH  = 2'd2,
    REG_GRID_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [0:0] {
    ACT_TRACE = 1'b0,
    ACT_READ  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

// ===== design/ortlo_ram.sv =====
module ortlo_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/occupancy_ray_trace_log_odds.sv =====
// Log-odds occupancy grid of 512 x 512 cells (signed Q3.8, saturating at +/-4.0) held
// in one single-port-write, single-port-read RAM. A trace item walks the Bresenham
// line from the start to the end cell at one cell per cycle: the read of a cell
// overlaps the write-back of the cell before it. After the end cell the sequencer
// passes through a drain state and a done state; in the done state the result is
// loaded into the output register that drives out_valid, and only then is the next
// item taken. A read item walks only its end cell, with no write-back. One RAM read
// per cell paces the walk; a result held on out_stall delays the loading of the next
// result. After reset a clearing pass writes zero to all 262144 cells, one per cycle,
// and no input item is taken until it ends; configuration writes are taken
// throughout. The next item may be transferred while a result still waits on
// out_stall.
module occupancy_ray_trace_log_odds (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [ortlo_pkg::COORD_W-1:0] in_start_x,
  input  logic [ortlo_pkg::COORD_W-1:0] in_start_y,
  input  logic [ortlo_pkg::COORD_W-1:0] in_end_x,
  input  logic [ortlo_pkg::COORD_W-1:0] in_end_y,
  input  logic                          in_beam_hit,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ortlo_pkg::VAL_W-1:0] out_cell_value,
  output logic [ortlo_pkg::CNT_W-1:0]   out_cells_updated,
  output logic                          out_endpoint_inside,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ortlo_pkg::CFG_AW-1:0]  paddr,
  input  logic [ortlo_pkg::CFG_DW-1:0]  pwdata,
  output logic [ortlo_pkg::CFG_DW-1:0]  prdata,
  output logic                          pready
);

  import ortlo_pkg::*;

  // Configuration registers
  logic signed [VAL_W-1:0] hit_step_r;
  logic signed [VAL_W-1:0] miss_step_r;
  logic [DIM_W-1:0]        grid_width_r;
  logic [DIM_W-1:0]        grid_height_r;

  // Sequencer
  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  // Walk registers
  logic [COORD_W-1:0]      x_r, x_nxt, y_r, y_nxt;
  logic [COORD_W-1:0]      ex_r, ex_nxt, ey_r, ey_nxt;
  logic signed [ERR_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt, err_r, err_nxt;
  logic                    stx_r, stx_nxt, sty_r, sty_nxt;
  logic                    hit_r, hit_nxt;
  action_t                 act_r, act_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;

  // Write-back stage: the cell whose read data arrives this cycle
  logic                    p1_valid_r, p1_valid_nxt;
  logic [ADDR_W-1:0]       p1_addr_r, p1_addr_nxt;
  logic                    p1_inside_r, p1_inside_nxt;
  logic                    p1_last_r, p1_last_nxt;
  logic                    p1_wr_r, p1_wr_nxt;
  logic signed [VAL_W-1:0] p1_step_r, p1_step_nxt;

  // Held result and output register
  logic signed [VAL_W-1:0] res_value_r, res_value_nxt;
  logic [CNT_W-1:0]        res_count_r, res_count_nxt;
  logic                    res_inside_r, res_inside_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;
  logic                    out_inside_r, out_inside_nxt;

  // RAM ports
  logic                    ram_wr_en;
  logic [ADDR_W-1:0]       ram_wr_addr;
  logic [VAL_W-1:0]        ram_wr_data;
  logic [ADDR_W-1:0]       ram_rd_addr;
  logic [VAL_W-1:0]        ram_rd_data;

  // Datapath helpers
  logic                    in_xfer;
  logic                    cfg_wr;
  logic                    at_end;
  logic                    cell_in;
  logic signed [ERR_W:0]   e2;
  logic                    step_x, step_y;
  logic [COORD_W-1:0]      adx, ady;
  logic signed [VAL_W:0]   sum;
  logic signed [VAL_W-1:0] sat;
  logic                    do_write;

  ortlo_ram #(
    .WIDTH (VAL_W),
    .DEPTH (GRID_CELLS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // ---------------------------------------------------------------------------
  // Configuration: write on the access phase; pready is tied high.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_step_r    <= VAL_W'(218);
      miss_step_r   <= -VAL_W'(102);
      grid_width_r  <= DIM_W'(400);
      grid_height_r <= DIM_W'(400);
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[CFG_AW-1:2]))
        REG_HIT_STEP:    hit_step_r    <= pwdata[VAL_W-1:0];
        REG_MISS_STEP:   miss_step_r   <= pwdata[VAL_W-1:0];
        REG_GRID_WIDTH:  grid_width_r  <= pwdata[DIM_W-1:0];
        REG_GRID_HEIGHT: grid_height_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[CFG_AW-1:2]))
      REG_HIT_STEP:    prdata = CFG_DW'(hit_step_r);
      REG_MISS_STEP:   prdata = CFG_DW'(miss_step_r);
      REG_GRID_WIDTH:  prdata = CFG_DW'(grid_width_r);
      REG_GRID_HEIGHT: prdata = CFG_DW'(grid_height_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;

  assign out_valid           = out_valid_r;
  assign out_cell_value      = out_value_r;
  assign out_cells_updated   = out_count_r;
  assign out_endpoint_inside = out_inside_r;

  // ---------------------------------------------------------------------------
  // Walk step: current cell, end test and Bresenham advance. Coordinates are
  // below GRID_SIDE, so x < grid_width alone matches the clamped bound.
  // ---------------------------------------------------------------------------
  assign at_end  = (x_r == ex_r) && (y_r == ey_r);
  assign cell_in = ({1'b0, x_r} < grid_width_r) && ({1'b0, y_r} < grid_height_r);
  assign e2      = {err_r, 1'b0};
  assign step_x  = (e2 >= $signed({dy_r[ERR_W-1], dy_r}));
  assign step_y  = (e2 <= $signed({dx_r[ERR_W-1], dx_r}));
  assign adx     = (in_end_x > in_start_x) ? in_end_x - in_start_x : in_start_x - in_end_x;
  assign ady     = (in_end_y > in_start_y) ? in_end_y - in_start_y : in_start_y - in_end_y;

  // Write-back: saturating add on the cell read in the previous cycle. Cells of
  // one line are distinct, so during the walk this write never hits the cell being read.
  assign sum      = {ram_rd_data[VAL_W-1], ram_rd_data} + {p1_step_r[VAL_W-1], p1_step_r};
  assign do_write = p1_valid_r && p1_wr_r && p1_inside_r;

  always_comb begin
    if (sum > LIMIT_WIDE) begin
      sat = LIMIT_WIDE[VAL_W-1:0];
    end else if (sum < -LIMIT_WIDE) begin
      sat = VAL_W'(-LIMIT_WIDE);
    end else begin
      sat = sum[VAL_W-1:0];
    end
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr_r;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = do_write;
      ram_wr_addr = p1_addr_r;
      ram_wr_data = sat;
    end
  end

  assign ram_rd_addr = {y_r, x_r};

  // ---------------------------------------------------------------------------
  // Sequencer and datapath next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    ex_nxt         = ex_r;
    ey_nxt         = ey_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    err_nxt        = err_r;
    stx_nxt        = stx_r;
    sty_nxt        = sty_r;
    hit_nxt        = hit_r;
    act_nxt        = act_r;
    count_nxt      = count_r + CNT_W'(do_write);
    p1_valid_nxt   = 1'b0;
    p1_addr_nxt    = p1_addr_r;
    p1_inside_nxt  = p1_inside_r;
    p1_last_nxt    = p1_last_r;
    p1_wr_nxt      = p1_wr_r;
    p1_step_nxt    = p1_step_r;
    res_value_nxt  = res_value_r;
    res_count_nxt  = res_count_r;
    res_inside_nxt = res_inside_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_inside_nxt = out_inside_r;

    // Capture the final cell as it leaves write-back
    if (p1_valid_r && p1_last_r) begin
      res_inside_nxt = p1_inside_r;
      res_count_nxt  = count_r + CNT_W'(do_write);
      if (!p1_inside_r) begin
        res_value_nxt = '0;
      end else if (p1_wr_r) begin
        res_value_nxt = sat;
      end else begin
        res_value_nxt = ram_rd_data;
      end
    end

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (&clr_addr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          act_nxt   = action_t'(in_action);
          hit_nxt   = in_beam_hit;
          ex_nxt    = in_end_x;
          ey_nxt    = in_end_y;
          count_nxt = '0;
          dx_nxt    = ERR_W'(adx);
          dy_nxt    = -ERR_W'(ady);
          err_nxt   = ERR_W'(adx) - ERR_W'(ady);
          stx_nxt   = (in_start_x < in_end_x);
          sty_nxt   = (in_start_y < in_end_y);
          // A read is a walk of one cell with no write-back
          if (action_t'(in_action) == ACT_READ) begin
            x_nxt = in_end_x;
            y_nxt = in_end_y;
          end else begin
            x_nxt = in_start_x;
            y_nxt = in_start_y;
          end
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        p1_valid_nxt  = 1'b1;
        p1_addr_nxt   = {y_r, x_r};
        p1_inside_nxt = cell_in;
        p1_last_nxt   = at_end;
        p1_wr_nxt     = (act_r == ACT_TRACE);
        p1_step_nxt   = (at_end && hit_r) ? hit_step_r : miss_step_r;
        if (at_end) begin
          state_nxt = ST_DRAIN;
        end else begin
          // Advance along the line
          err_nxt = err_r + (step_x ? dy_r : '0) + (step_y ? dx_r : '0);
          if (step_x) begin
            x_nxt = stx_r ? x_r + COORD_W'(1) : x_r - COORD_W'(1);
          end
          if (step_y) begin
            y_nxt = sty_r ? y_r + COORD_W'(1) : y_r - COORD_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hold the result until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_count_nxt  = res_count_r;
          out_inside_nxt = res_inside_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    ex_r         <= ex_nxt;
    ey_r         <= ey_nxt;
    dx_r         <= dx_nxt;
    dy_r         <= dy_nxt;
    err_r        <= err_nxt;
    stx_r        <= stx_nxt;
    sty_r        <= sty_nxt;
    hit_r        <= hit_nxt;
    act_r        <= act_nxt;
    count_r      <= count_nxt;
    p1_addr_r    <= p1_addr_nxt;
    p1_inside_r  <= p1_inside_nxt;
    p1_last_r    <= p1_last_nxt;
    p1_wr_r      <= p1_wr_nxt;
    p1_step_r    <= p1_step_nxt;
    res_value_r  <= res_value_nxt;
    res_count_r  <= res_count_nxt;
    res_inside_r <= res_inside_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_inside_r <= out_inside_nxt;
  end

endmodule

// ===== design/ortlo_checker.sv =====
module ortlo_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [ortlo_pkg::VAL_W-1:0] out_cell_value,
  input logic [ortlo_pkg::CNT_W-1:0]        out_cells_updated,
  input logic                               out_endpoint_inside
);

  import ortlo_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // An endpoint outside the grid reads as zero
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_endpoint_inside |-> out_cell_value == '0)
    else $error("nonzero value for outside endpoint");

  // Cell values stay within the saturation bound
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed({out_cell_value[VAL_W-1], out_cell_value}) <= LIMIT_WIDE) &&
                  ($signed({out_cell_value[VAL_W-1], out_cell_value}) >= -LIMIT_WIDE))
    else $error("cell value beyond saturation bound");

  // No more cells than one line across the grid can touch
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cells_updated <= CNT_W'(GRID_SIDE))
    else $error("cell count beyond grid side");

  // The block is busy right after taking an item
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without walking");

endmodule

bind occupancy_ray_trace_log_odds ortlo_checker u_ortlo_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_cell_value      (out_cell_value),
  .out_cells_updated   (out_cells_updated),
  .out_endpoint_inside (out_endpoint_inside)
);

// ===== verif/occupancy_ray_trace_log_odds_tb.sv =====
module occupancy_ray_trace_log_odds_tb;
  import ortlo_pkg::*;

  // Quiet cycles allowed before giving up: the clearing pass alone keeps both
  // channels silent for a full sweep of the grid, so allow it several times over.
  localparam int WATCHDOG_LIMIT = 3 * GRID_CELLS;
  // Longest ray plus pipeline slack, used for the final settle period.
  localparam int SETTLE_CYCLES  = GRID_SIDE + 16;

  typedef struct packed {
    action_t              action;
    logic [COORD_W-1:0]   start_x;
    logic [COORD_W-1:0]   start_y;
    logic [COORD_W-1:0]   end_x;
    logic [COORD_W-1:0]   end_y;
    logic                 beam_hit;
  } ray_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] cell_value;
    logic [CNT_W-1:0]        cells_updated;
    logic                    endpoint_inside;
  } cell_report_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                      in_valid;
  logic                      in_stall;
  logic                      in_action;
  logic [COORD_W-1:0]        in_start_x;
  logic [COORD_W-1:0]        in_start_y;
  logic [COORD_W-1:0]        in_end_x;
  logic [COORD_W-1:0]        in_end_y;
  logic                      in_beam_hit;

  logic                      out_valid;
  logic                      out_stall;
  logic signed [VAL_W-1:0]   out_cell_value;
  logic [CNT_W-1:0]          out_cells_updated;
  logic                      out_endpoint_inside;

  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [CFG_AW-1:0]         paddr;
  logic [CFG_DW-1:0]         pwdata;
  logic [CFG_DW-1:0]         prdata;
  logic                      pready;

  occupancy_ray_trace_log_odds uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_start_x          (in_start_x),
    .in_start_y          (in_start_y),
    .in_end_x            (in_end_x),
    .in_end_y            (in_end_y),
    .in_beam_hit         (in_beam_hit),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cell_value      (out_cell_value),
    .out_cells_updated   (out_cells_updated),
    .out_endpoint_inside (out_endpoint_inside),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror of the grid and of the programmed registers, kept in transfer order.
  logic signed [VAL_W-1:0] log_odds_mirror [GRID_CELLS];
  int hit_gain;
  int miss_gain;
  int cols_in_use;
  int rows_in_use;

  ray_item_t    pending_rays[$];
  cell_report_t awaited_reports[$];

  int  mismatches;
  int  traces_sent;
  int  reads_sent;
  int  reports_checked;
  int  settings_run;
  int  quiet_cycles;
  int  last_end_x;
  int  last_end_y;
  logic calm_stretch;

  // ---------------------------------------------------------------------------
  // Grid predictor
  // ---------------------------------------------------------------------------

  // A cell counts only inside the programmed extent, itself capped at the grid side.
  function automatic bit cell_inside(input int x, input int y);
    int w;
    int h;
    w = (cols_in_use < GRID_SIDE) ? cols_in_use : GRID_SIDE;
    h = (rows_in_use < GRID_SIDE) ? rows_in_use : GRID_SIDE;
    return x >= 0 && y >= 0 && x < w && y < h;
  endfunction

  // Add a step with saturation at +/-4.0; report whether the cell was touched.
  function automatic int bump_cell(input int x, input int y, input int step);
    int v;
    if (!cell_inside(x, y)) return 0;
    v = log_odds_mirror[y * GRID_SIDE + x] + step;
    if (v > LIMIT_POS) v = LIMIT_POS;
    if (v < -LIMIT_POS) v = -LIMIT_POS;
    log_odds_mirror[y * GRID_SIDE + x] = v[VAL_W-1:0];
    return 1;
  endfunction

  // For a trace, walk the Bresenham line, apply the free-cell step to every cell before the
  // end and the end step to the end cell; for both actions, report the end cell.
  function automatic cell_report_t trace_ray(input ray_item_t r);
    cell_report_t rep;
    int x, y, ex, ey, dx, dy, stx, sty, err, e2, touched;
    x = int'(r.start_x);
    y = int'(r.start_y);
    ex = int'(r.end_x);
    ey = int'(r.end_y);
    touched = 0;
    if (r.action == ACT_TRACE) begin
      dx  = (ex > x) ? ex - x : x - ex;
      dy  = (ey > y) ? y - ey : ey - y;
      stx = (x < ex) ? 1 : -1;
      sty = (y < ey) ? 1 : -1;
      err = dx + dy;
      while (x != ex || y != ey) begin
        e2 = 2 * err;
        touched += bump_cell(x, y, miss_gain);
        if (e2 >= dy) begin
          err += dy;
          x += stx;
        end
        if (e2 <= dx) begin
          err += dx;
          y += sty;
        end
      end
      touched += bump_cell(ex, ey, r.beam_hit ? hit_gain : miss_gain);
    end
    rep.endpoint_inside = cell_inside(ex, ey);
    rep.cell_value      = rep.endpoint_inside ? log_odds_mirror[ey * GRID_SIDE + ex] : '0;
    rep.cells_updated   = touched[CNT_W-1:0];
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Favour coordinates inside the programmed extent, but still reach the far edge.
  function automatic logic [COORD_W-1:0] pick_coord(input int extent);
    int span;
    span = (extent < GRID_SIDE) ? extent : GRID_SIDE;
    if (span > 0 && $urandom_range(99) < 80) return COORD_W'($urandom_range(span - 1));
    return COORD_W'($urandom_range(GRID_SIDE - 1));
  endfunction

  // Jitter a coordinate and clamp it to the grid; clamping also feeds the edges.
  function automatic logic [COORD_W-1:0] near(input int c, input int reach);
    int v;
    v = c + int'($urandom_range(2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > GRID_SIDE - 1) v = GRID_SIDE - 1;
    return v[COORD_W-1:0];
  endfunction

  function automatic ray_item_t random_ray();
    ray_item_t r;
    int roll;
    int reach;
    roll       = $urandom_range(99);
    r.beam_hit = 1'($urandom_range(1));
    r.start_x  = COORD_W'($urandom_range(GRID_SIDE - 1));
    r.start_y  = COORD_W'($urandom_range(GRID_SIDE - 1));
    if (roll < 15) begin
      // Reads: half revisit the latest endpoint to see accumulated evidence.
      r.action = ACT_READ;
      if ($urandom_range(1)) begin
        r.end_x = near(last_end_x, 2);
        r.end_y = near(last_end_y, 2);
      end else begin
        r.end_x = pick_coord(cols_in_use);
        r.end_y = pick_coord(rows_in_use);
      end
    end else begin
      r.action  = ACT_TRACE;
      r.start_x = pick_coord(cols_in_use);
      r.start_y = pick_coord(rows_in_use);
      roll = $urandom_range(99);
      if (roll < 90) begin
        // Mostly short rays keep the run brief; some reach further.
        reach   = (roll < 70) ? 31 : 127;
        r.end_x = near(int'(r.start_x), reach);
        r.end_y = near(int'(r.start_y), reach);
      end else begin
        r.end_x = COORD_W'($urandom_range(GRID_SIDE - 1));
        r.end_y = COORD_W'($urandom_range(GRID_SIDE - 1));
      end
      // Re-hit a recent endpoint now and then so cells drift into saturation.
      if ($urandom_range(3) == 0) begin
        r.end_x = near(last_end_x, 3);
        r.end_y = near(last_end_y, 3);
      end
      last_end_x = int'(r.end_x);
      last_end_y = int'(r.end_y);
    end
    return r;
  endfunction

  task automatic queue_ray(input action_t act, input int sx, input int sy,
                           input int ex, input int ey, input bit hit);
    ray_item_t r;
    r.action   = act;
    r.start_x  = sx[COORD_W-1:0];
    r.start_y  = sy[COORD_W-1:0];
    r.end_x    = ex[COORD_W-1:0];
    r.end_y    = ey[COORD_W-1:0];
    r.beam_hit = hit;
    pending_rays = {pending_rays, r};
  endtask

  // Hold until every queued ray has been transferred and every report seen.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_rays.size() != 0 || in_valid || awaited_reports.size() != 0);
  endtask

  // Setup cycle, then access cycle; the register lands at the edge where pready is high.
  task automatic write_reg(input reg_idx_t idx, input int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HIT_STEP:    hit_gain    = int'($signed(value[VAL_W-1:0]));
      REG_MISS_STEP:   miss_gain   = int'($signed(value[VAL_W-1:0]));
      REG_GRID_WIDTH:  cols_in_use = int'(value[DIM_W-1:0]);
      REG_GRID_HEIGHT: rows_in_use = int'(value[DIM_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic program_grid(input int hit, input int miss, input int w, input int h);
    write_reg(REG_HIT_STEP, hit);
    write_reg(REG_MISS_STEP, miss);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    settings_run++;
  endtask

  task automatic run_phase(input int count);
    repeat (count) pending_rays = {pending_rays, random_ray()};
    wait_drained();
  endtask

  task automatic flag_field(input string field, input int want, input int got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: when the slot is free or transfers, launch the next ray or, outside a calm stretch, idle at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_rays
    ray_item_t sent;
    ray_item_t next_ray;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        // Transfer at this edge: advance the mirror and record what must come back.
        sent.action   = action_t'(in_action);
        sent.start_x  = in_start_x;
        sent.start_y  = in_start_y;
        sent.end_x    = in_end_x;
        sent.end_y    = in_end_y;
        sent.beam_hit = in_beam_hit;
        if (sent.action == ACT_TRACE) traces_sent++;
        else reads_sent++;
        awaited_reports = {awaited_reports, trace_ray(sent)};
      end
      if (pending_rays.size() != 0 && (calm_stretch || $urandom_range(99) >= 19)) begin
        next_ray    = pending_rays.pop_front();
        in_valid    <= 1'b1;
        in_action   <= next_ray.action;
        in_start_x  <= next_ray.start_x;
        in_start_y  <= next_ray.start_y;
        in_end_x    <= next_ray.end_x;
        in_end_y    <= next_ray.end_y;
        in_beam_hit <= next_ray.beam_hit;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each transfer with the oldest awaited report.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_reports
    cell_report_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing awaited, expected none, got %0d",
                   $time, out_cell_value);
        end else begin
          want = awaited_reports.pop_front();
          reports_checked++;
          if (out_cell_value !== want.cell_value)
            flag_field("cell_value", want.cell_value, out_cell_value);
          if (out_cells_updated !== want.cells_updated)
            flag_field("cells_updated", want.cells_updated, out_cells_updated);
          if (out_endpoint_inside !== want.endpoint_inside)
            flag_field("endpoint_inside", want.endpoint_inside, out_endpoint_inside);
        end
      end
      out_stall <= !calm_stretch && ($urandom_range(99) < 19);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles with no transfer on either channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("occupancy_ray_trace_log_odds_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed rays, then random phases under several settings.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_action    = 1'b0;
    in_start_x   = '0;
    in_start_y   = '0;
    in_end_x     = '0;
    in_end_y     = '0;
    in_beam_hit  = 1'b0;
    out_stall    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    calm_stretch = 1'b0;
    mismatches   = 0;
    traces_sent  = 0;
    reads_sent   = 0;
    reports_checked = 0;
    settings_run = 1;
    quiet_cycles = 0;
    last_end_x   = 0;
    last_end_y   = 0;
    hit_gain     = 218;
    miss_gain    = -102;
    cols_in_use  = 400;
    rows_in_use  = 400;
    for (int i = 0; i < GRID_CELLS; i++) log_odds_mirror[i] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rays under the reset settings. Reads first: the grid is clear.
    queue_ray(ACT_READ,  0, 0, 0, 0, 1'b0);
    queue_ray(ACT_READ,  511, 511, 511, 511, 1'b1);         // endpoint beyond the extent
    queue_ray(ACT_TRACE, 5, 5, 5, 5, 1'b1);                 // start equals end, hit
    queue_ray(ACT_TRACE, 5, 5, 5, 5, 1'b0);                 // start equals end, miss
    queue_ray(ACT_TRACE, 0, 0, 511, 511, 1'b1);             // ray leaves the grid
    queue_ray(ACT_TRACE, 511, 0, 0, 511, 1'b0);             // ray enters from outside
    queue_ray(ACT_TRACE, 0, 10, 399, 10, 1'b0);             // horizontal, edge to edge
    queue_ray(ACT_TRACE, 20, 399, 20, 0, 1'b1);             // vertical, walking upward
    queue_ray(ACT_TRACE, 3, 100, 10, 300, 1'b1);            // steep slope
    queue_ray(ACT_TRACE, 300, 7, 0, 50, 1'b0);              // shallow slope, leftward
    repeat (6) queue_ray(ACT_TRACE, 45, 50, 50, 50, 1'b1);  // drive the end to +4.0
    repeat (5) queue_ray(ACT_TRACE, 30, 50, 49, 50, 1'b0);  // drive free cells 45 to 49 to -4.0
    queue_ray(ACT_READ,  0, 0, 50, 50, 1'b1);
    queue_ray(ACT_READ,  0, 0, 47, 50, 1'b0);
    queue_ray(ACT_READ,  0, 0, 399, 399, 1'b1);             // last inside corner
    queue_ray(ACT_READ,  0, 0, 400, 10, 1'b0);              // first column outside
    wait_drained();

    run_phase(300);

    // Steps beyond +/-4.0 saturate on every touch; the full grid is in use.
    program_grid(2047, -2048, GRID_SIDE, GRID_SIDE);
    run_phase(150);

    // Extent larger than the grid, with no idling on either side.
    calm_stretch <= 1'b1;
    program_grid(1024, -1024, 1023, 1023);
    run_phase(150);
    calm_stretch <= 1'b0;

    // Inverted step signs on a one-cell grid.
    program_grid(-1024, 1024, 1, 1);
    run_phase(100);

    // Empty extent: nothing is inside, traces change nothing.
    program_grid(int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048, 0, 0);
    run_phase(60);

    // Zero steps on a single row.
    program_grid(0, 0, GRID_SIDE, 1);
    run_phase(60);

    repeat (4) begin
      program_grid(int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                   ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(GRID_SIDE, 1),
                   ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(GRID_SIDE, 1));
      run_phase(80);
    end

    // Let any stray result surface before judging.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_reports.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived, expected cell_value %0d, got none",
               $time, awaited_reports.size(), awaited_reports[0].cell_value);
    end

    $display("Ran %0d traces and %0d reads across %0d grid settings; %0d results compared.",
             traces_sent, reads_sent, settings_run, reports_checked);
    $display("Settings spanned saturating and zero steps, empty, single-cell and oversized grids.");
    if (mismatches == 0) begin
      $display("occupancy_ray_trace_log_odds_tb OK");
    end else begin
      $display("occupancy_ray_trace_log_odds_tb NOT OK");
    end
    $finish;
  end

endmodule
